// File: design/lfrc_pkg.sv
// Shared types and constants for the loop-filter / residual-combine block.
// No dependencies.
`default_nettype none

package lfrc_pkg;

    localparam int SIDE       = 8;
    localparam int CELLS      = SIDE * SIDE;
    localparam int POS_W      = $clog2(CELLS);
    localparam int ADDR_W     = POS_W + 1;          // bank bit on top of raster index
    localparam int STEP_W     = 7;
    localparam int PIX_W      = 8;
    localparam int VAL_W      = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(CELLS - 1);
    localparam logic [2:0]        EDGE_LAST  = 3'(SIDE - 1);
    // back sweep: pixel read, window shift, 9-deep look-ahead, result register
    localparam logic [STEP_W-1:0] VAL_LEAD   = STEP_W'(10);
    localparam logic [STEP_W-1:0] FIRST_OUT  = STEP_W'(11);
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(CELLS + 10);

    localparam logic MODE_SUB = 1'b0;
    localparam logic MODE_ADD = 1'b1;

    typedef struct packed {
        logic bank;
        logic mode;
        logic filt;
    } blk_desc_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pixel;
        logic [VAL_W-1:0]  value;
    } store_wr_t;

endpackage

`default_nettype wire

// File: design/lfrc_front.sv
// Input side: takes words, writes them into the current store bank and
// posts a block descriptor once 64 words are in. Uses lfrc_pkg.
`default_nettype none

module lfrc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic                        filter_on,
    input  logic [7:0]                  pred_pixel,
    input  logic signed [15:0]          block_value,
    input  logic                        q_full,
    output lfrc_pkg::store_wr_t         wr,
    output logic                        push,
    output lfrc_pkg::blk_desc_t         push_desc
);
    import lfrc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             bank_reg, bank_next;
    logic             mode_reg, mode_next;
    logic             filt_reg, filt_next;
    logic             accept;

    // a full queue means the bank we would write is still being read
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        pos_next  = pos_reg;
        bank_next = bank_reg;
        mode_next = mode_reg;
        filt_next = filt_reg;
        if (accept)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == '0)
            begin
                mode_next = mode;
                filt_next = filter_on;
            end
            if (pos_reg == POS_LAST)
                bank_next = !bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            bank_reg <= 1'b0;
            mode_reg <= 1'b0;
            filt_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            bank_reg <= bank_next;
            mode_reg <= mode_next;
            filt_reg <= filt_next;
        end
    end

    assign wr.en    = accept;
    assign wr.addr  = {bank_reg, pos_reg};
    assign wr.pixel = pred_pixel;
    assign wr.value = block_value;

    assign push           = accept && (pos_reg == POS_LAST);
    assign push_desc.bank = bank_reg;
    assign push_desc.mode = mode_reg;
    assign push_desc.filt = filt_reg;

endmodule

`default_nettype wire

// File: design/lfrc_queue.sv
// Two-entry descriptor queue between front and back, one entry per full bank.
// Uses lfrc_pkg.
`default_nettype none

module lfrc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lfrc_pkg::blk_desc_t push_desc,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output lfrc_pkg::blk_desc_t head
);
    import lfrc_pkg::*;

    blk_desc_t         ents_reg [QUEUE_DEPTH];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = ents_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ents_reg[wr_ptr_reg] <= push_desc;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("descriptor pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("descriptor popped from empty queue");

endmodule

`default_nettype wire

// File: design/lfrc_back.sv
// Back end: owns the double-banked pixel/value stores, sweeps one bank per
// block through a 3x3 window, filters, combines and drives the output word.
// Uses lfrc_pkg.
`default_nettype none

module lfrc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lfrc_pkg::store_wr_t wr,
    input  logic                head_valid,
    input  lfrc_pkg::blk_desc_t head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  result_value,
    output logic                last
);
    import lfrc_pkg::*;

    localparam int WIN = 2 * SIDE + 3;

    logic [PIX_W-1:0]  pix_mem [2*CELLS];
    logic [VAL_W-1:0]  val_mem [2*CELLS];
    logic [PIX_W-1:0]  pix_rd_reg;
    logic [VAL_W-1:0]  val_rd_reg;
    logic [PIX_W-1:0]  win_reg [WIN];

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg;
    logic [VAL_W-1:0]  out_value_reg;

    logic              adv;
    logic              emit;
    logic [STEP_W-1:0] val_step;
    logic [STEP_W-1:0] cur_step;
    logic [POS_W-1:0]  cur_pos;
    logic              col_edge;
    logic              row_edge;
    logic [9:0]        h_up, h_mid, h_dn;
    logic [11:0]       v_sum;
    logic [11:0]       v_round;
    logic [PIX_W-1:0]  pred;
    logic [VAL_W-1:0]  combined;

    // 1-2-1 along a row; an edge column takes the center at weight 4
    function automatic logic [9:0] tap3(input logic [7:0] l, input logic [7:0] c,
                                        input logic [7:0] r, input logic edge_c);
        logic [9:0] s;
        if (edge_c)
            s = {c, 2'b00};
        else
            s = {2'b00, l} + {1'b0, c, 1'b0} + {2'b00, r};
        return s;
    endfunction

    assign adv  = head_valid && (!out_valid_reg || !out_stall);
    assign emit = (step_reg >= FIRST_OUT);
    assign pop  = adv && (step_reg == STEP_LAST);

    assign val_step = step_reg - VAL_LEAD;
    assign cur_step = step_reg - FIRST_OUT;
    assign cur_pos  = cur_step[POS_W-1:0];
    assign col_edge = (cur_pos[2:0] == 3'd0) || (cur_pos[2:0] == EDGE_LAST);
    assign row_edge = (cur_pos[5:3] == 3'd0) || (cur_pos[5:3] == EDGE_LAST);

    // window: tap 9 is the center, 0 is down-right, 18 is up-left
    assign h_up  = tap3(win_reg[18], win_reg[17], win_reg[16], col_edge);
    assign h_mid = tap3(win_reg[10], win_reg[9],  win_reg[8],  col_edge);
    assign h_dn  = tap3(win_reg[2],  win_reg[1],  win_reg[0],  col_edge);

    always_comb
    begin
        if (row_edge)
            v_sum = {h_mid, 2'b00};
        else
            v_sum = {2'b00, h_up} + {1'b0, h_mid, 1'b0} + {2'b00, h_dn};
    end

    assign v_round = v_sum + 12'd8;
    assign pred    = head.filt ? v_round[11:4] : win_reg[9];

    always_comb
    begin
        unique case (head.mode)
            MODE_ADD: combined = val_rd_reg + {{(VAL_W-PIX_W){1'b0}}, pred};
            MODE_SUB: combined = val_rd_reg - {{(VAL_W-PIX_W){1'b0}}, pred};
            default:  combined = val_rd_reg;
        endcase
    end

    // stores: write from the front, read one bank per sweep
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            pix_mem[wr.addr] <= wr.pixel;
            val_mem[wr.addr] <= wr.value;
        end
        if (adv)
        begin
            pix_rd_reg <= pix_mem[{head.bank, step_reg[POS_W-1:0]}];
            val_rd_reg <= val_mem[{head.bank, val_step[POS_W-1:0]}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            win_reg[0] <= pix_rd_reg;
            for (int i = 1; i < WIN; i++)
                win_reg[i] <= win_reg[i-1];
        end
    end

    always_comb
    begin
        step_next = step_reg;
        if (adv)
            step_next = (step_reg == STEP_LAST) ? '0 : step_reg + STEP_W'(1);
        out_valid_next = out_valid_reg && out_stall;
        if (adv && emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            out_value_reg <= combined;
            out_last_reg  <= (step_reg == STEP_LAST);
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign last         = out_last_reg;

    a_bank_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.en && head_valid) |-> (wr.addr[ADDR_W-1] != head.bank))
        else $error("front writes the bank being swept");

    a_last_follows_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && out_last_reg && step_reg == '0))
        else $error("end of sweep without last word");

endmodule

`default_nettype wire

// File: design/loop_filter_residual_combine.sv
// Top level of the 8x8 loop-filter / residual-combine block.
// Depends on lfrc_pkg, lfrc_front, lfrc_queue, lfrc_back.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------
//   in      | in_valid, in_stall  | mode, filter_on, pred_pixel, block_value
//   out     | out_valid, out_stall| result_value, last
//
// Input words are taken one per cycle while in_stall is low, into one of two
// store banks; a full bank is swept by the back end, one bank at a time, with
// 64 reads plus a window fill.
// The sweep of a bank starts only once its 64th input word is in.
// Reset clears pointers, counters and valids; store contents are undefined.
// in_stall rises while both banks hold blocks not yet fully swept; out_stall holds the
// output register and pauses the sweep.
`default_nettype none

module loop_filter_residual_combine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic               filter_on,
    input  logic [7:0]         pred_pixel,
    input  logic signed [15:0] block_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] result_value,
    output logic               last
);
    import lfrc_pkg::*;

    store_wr_t wr;
    blk_desc_t push_desc;
    blk_desc_t head;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      head_valid;

    lfrc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .filter_on   (filter_on),
        .pred_pixel  (pred_pixel),
        .block_value (block_value),
        .q_full      (q_full),
        .wr          (wr),
        .push        (push),
        .push_desc   (push_desc)
    );

    lfrc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    lfrc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (wr),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .last         (last)
    );

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking bench for loop_filter_residual_combine: streams 8x8 blocks in
// bursts and checks every result word against an in-bench block model.
// Depends on lfrc_pkg and the design sources.
`timescale 1ns / 100ps

module tb;
    import lfrc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 120;
    localparam int RANDOM_BLOCKS = 1;

    typedef struct {
        logic        mode;
        logic        filt;
        logic [7:0]  pix;
        logic [15:0] val;
    } word_t;

    typedef struct {
        logic [15:0] value;
        logic        last;
    } result_t;

    typedef enum {FILL_MIN, FILL_MAX, FILL_CHECKER, FILL_RAMP, FILL_RANDOM} fill_t;
    typedef enum {RX_FREE, RX_HOLD, RX_COIN} rx_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               mode = MODE_SUB;
    logic               filter_on = 1'b0;
    logic [7:0]         pred_pixel = '0;
    logic signed [15:0] block_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] result_value;
    logic               last;

    loop_filter_residual_combine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .filter_on    (filter_on),
        .pred_pixel   (pred_pixel),
        .block_value  (block_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    word_t   stim_q[$];
    result_t combined_q[$];
    int      cycles = 0;
    int      errors = 0;
    int      taken_cnt = 0;
    int      drv_next = 0;
    int      gap_left = 0;
    int      burst_left = 8;
    int      rx_left = 0;
    rx_t     rx_mode = RX_FREE;

    // block model state
    logic [7:0]  pix_mem [CELLS];
    logic [15:0] val_mem [CELLS];
    int          fill_pos = 0;
    logic        blk_mode = MODE_SUB;
    logic        blk_filt = 1'b0;
    result_t     seen;

    task automatic queue_block(input logic m, input logic f, input fill_t fill);
        word_t w;
        for (int k = 0; k < CELLS; k++)
        begin
            // flags past the first word must be ignored: flip or randomize them
            if (k == 0)
            begin
                w.mode = m;
                w.filt = f;
            end
            else if (fill == FILL_RANDOM)
            begin
                w.mode = 1'($urandom);
                w.filt = 1'($urandom);
            end
            else
            begin
                w.mode = ~m;
                w.filt = ~f;
            end
            case (fill)
                FILL_MIN:
                begin
                    w.pix = 8'hFF;
                    w.val = 16'h8000;
                end
                FILL_MAX:
                begin
                    w.pix = 8'hFF;
                    w.val = 16'h7FFF;
                end
                FILL_CHECKER:
                begin
                    w.pix = (((k / SIDE) + k) % 2 != 0) ? 8'hFF : 8'h00;
                    w.val = (k % 2 != 0) ? 16'h7FFF : 16'h8000;
                end
                FILL_RAMP:
                begin
                    w.pix = 8'(k * 4);
                    w.val = 16'(k * 1021 - 30000);
                end
                default:
                begin
                    w.pix = 8'($urandom);
                    w.val = 16'($urandom);
                end
            endcase
            stim_q.push_back(w);
        end
    endtask

    // Accepts one input word; on the 64th, computes the whole block of results.
    task automatic absorb_word(input logic m, input logic f, input logic [7:0] p,
                               input logic [15:0] v);
        int      horiz [CELLS];
        int      r;
        int      c;
        int      sum;
        int      pred;
        result_t e;
        if (fill_pos == 0)
        begin
            blk_mode = m;
            blk_filt = f;
        end
        pix_mem[fill_pos] = p;
        val_mem[fill_pos] = v;
        if (fill_pos != CELLS - 1)
        begin
            fill_pos++;
            return;
        end
        fill_pos = 0;

        for (int at = 0; at < CELLS; at++)
        begin
            c = at % SIDE;
            if (c == 0 || c == SIDE - 1)
                horiz[at] = int'(pix_mem[at]) * 4;
            else
                horiz[at] = int'(pix_mem[at - 1]) + 2 * int'(pix_mem[at])
                          + int'(pix_mem[at + 1]);
        end
        for (int at = 0; at < CELLS; at++)
        begin
            r = at / SIDE;
            if (!blk_filt)
                pred = int'(pix_mem[at]);
            else
            begin
                if (r == 0 || r == SIDE - 1)
                    sum = horiz[at] * 4;
                else
                    sum = horiz[at - SIDE] + 2 * horiz[at] + horiz[at + SIDE];
                pred = (sum + 8) >> 4;
            end
            if (blk_mode == MODE_ADD)
                e.value = 16'(int'(val_mem[at]) + pred);
            else
                e.value = 16'(int'(val_mem[at]) - pred);
            e.last = (at == CELLS - 1);
            combined_q.push_back(e);
        end
    endtask

    always @(posedge clk)
        cycles <= cycles + 1;

    // monitor: sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (combined_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word: value=%0d last=%0b",
                             $time, result_value, last);
                end
                else
                begin
                    seen = combined_q.pop_front();
                    if (result_value !== seen.value || last !== seen.last)
                    begin
                        errors++;
                        $display({"%0t: result mismatch: expected value=%0d last=%0b,",
                                  " got value=%0d last=%0b"},
                                 $time, $signed(seen.value), seen.last, result_value, last);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                absorb_word(mode, filter_on, pred_pixel, block_value);
                taken_cnt <= taken_cnt + 1;
            end
        end
    end

    // driver: bursts with random gaps, holds the word while stalled
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && taken_cnt < drv_next)
                ;
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (drv_next < stim_q.size())
            begin
                in_valid    <= 1'b1;
                mode        <= stim_q[drv_next].mode;
                filter_on   <= stim_q[drv_next].filt;
                pred_pixel  <= stim_q[drv_next].pix;
                block_value <= stim_q[drv_next].val;
                drv_next    <= drv_next + 1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern: free stretches, solid holds, coin-flip stretches
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_left == 0)
            begin
                rx_mode <= rx_t'($urandom_range(0, 2));
                rx_left <= $urandom_range(4, 24);
            end
            else
                rx_left <= rx_left - 1;
            out_stall <= (rx_mode == RX_HOLD)
                      || (rx_mode == RX_COIN && $urandom_range(0, 1) == 1);
        end
    end

    initial
    begin
        queue_block(MODE_SUB, 1'b0, FILL_MIN);
        queue_block(MODE_ADD, 1'b1, FILL_RAMP);
        for (int b = 0; b < RANDOM_BLOCKS; b++)
            queue_block(1'($urandom), 1'($urandom), FILL_RANDOM);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (taken_cnt == stim_q.size());
        wait (combined_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("%0t: timeout, %0d words still expected", $time, combined_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
design/lfrc_pkg.sv
design/lfrc_front.sv
design/lfrc_queue.sv
design/lfrc_back.sv
design/loop_filter_residual_combine.sv
verif/tb.sv
